// ===== sv/bfds_pkg.sv =====
`timescale 1ns / 1ps

package bfds_pkg;

    localparam int ID_W   = 6;
    localparam int POS_W  = 16;
    localparam int MAG_W  = 16;
    localparam int SQ_W   = 32;
    localparam int DIST_W = 34;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;

    // One kept object as held in a cell of the chain.
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic shift;
    } ctrl_t;

    // An object leaving the distance pipeline.
    typedef struct packed {
        logic              valid;
        logic              blend;
        logic              last;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] sq_dist;
    } dist_t;

endpackage

// ===== sv/back_to_front_depth_sort_top.sv =====
`timescale 1ns / 1ps

// Back-to-front depth sort of blended scene objects.
// Objects are offered on start with object_id, is_blend, pos_x/y/z and
// last_object; a transfer takes place at a rising edge where start is high
// and busy is low. Camera position is set through cfg_we, cfg_index and
// cfg_data (index 0, 1, 2 for x, y, z); other indexes are ignored.
// Objects may be offered every cycle while busy is low. Each object passes
// through the distance pipeline (difference, square, sum) and is then
// inserted into a chain of MAX_OBJECTS cells kept in far-to-near order.
// Once the object marked last has been accepted, busy stays high until
// the kept set has been emitted. The first result follows that transfer
// through the distance pipeline and the drain flag, then one result per
// cycle for n kept objects, each shown for exactly one cycle with
// result_valid high and last_result on the final, nearest one. The chain
// shifts towards its head while draining. An empty set gives no results.
// Blend objects beyond MAX_OBJECTS are dropped. The receiver cannot
// stall the output.
// Reset empties the set and clears the camera position to zero.

module back_to_front_depth_sort_top
#(
    parameter int MAX_OBJECTS = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [bfds_pkg::ID_W-1:0]              object_id,
    input  logic                                   is_blend,
    input  logic signed [bfds_pkg::POS_W-1:0]      pos_x,
    input  logic signed [bfds_pkg::POS_W-1:0]      pos_y,
    input  logic signed [bfds_pkg::POS_W-1:0]      pos_z,
    input  logic                                   last_object,
    input  logic                                   cfg_we,
    input  logic [bfds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bfds_pkg::POS_W-1:0]             cfg_data,
    output logic                                   result_valid,
    output logic [bfds_pkg::ID_W-1:0]              sorted_id,
    output logic [bfds_pkg::DIST_W-1:0]            distance_sq,
    output logic                                   last_result
);

    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

    logic signed [bfds_pkg::POS_W-1:0] cam_x_reg;
    logic signed [bfds_pkg::POS_W-1:0] cam_y_reg;
    logic signed [bfds_pkg::POS_W-1:0] cam_z_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_after;
    logic             drain_reg;
    logic             accept;
    logic             last_pending;

    logic                          result_valid_reg;
    logic [bfds_pkg::ID_W-1:0]     sorted_id_reg;
    logic [bfds_pkg::DIST_W-1:0]   distance_sq_reg;
    logic                          last_result_reg;

    bfds_pkg::dist_t  obj;
    bfds_pkg::ctrl_t  ctrl;
    bfds_pkg::entry_t new_entry;
    bfds_pkg::entry_t entries [MAX_OBJECTS];
    logic             keeps   [MAX_OBJECTS];

    assign accept = start && !busy;
    assign busy   = last_pending || drain_reg;

    // Camera registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfds_pkg::CFG_CAM_X: cam_x_reg <= cfg_data;
                bfds_pkg::CFG_CAM_Y: cam_y_reg <= cfg_data;
                bfds_pkg::CFG_CAM_Z: cam_z_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    bfds_dist u_dist
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .object_id    (object_id),
        .is_blend     (is_blend),
        .last_object  (last_object),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .cam_x        (cam_x_reg),
        .cam_y        (cam_y_reg),
        .cam_z        (cam_z_reg),
        .result       (obj),
        .last_pending (last_pending)
    );

    // A blend object is inserted unless the chain is already full. While
    // draining, the chain moves one place towards its head every cycle.
    always_comb
    begin
        ctrl.ins          = obj.valid && obj.blend && (count_reg < CNT_W'(MAX_OBJECTS));
        ctrl.shift        = drain_reg;
        new_entry.sq_dist = obj.sq_dist;
        new_entry.id      = obj.id;
        count_after       = count_reg + CNT_W'(ctrl.ins);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_OBJECTS; g++)
        begin : g_cell
            bfds_pkg::entry_t prev_e;
            bfds_pkg::entry_t next_e;
            logic             prev_k;
            logic             occ;

            assign occ = CNT_W'(g) < count_reg;

            if (g == 0)
            begin : g_head
                assign prev_e = '0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = entries[g-1];
                assign prev_k = keeps[g-1];
            end

            if (g == MAX_OBJECTS - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = entries[g+1];
            end

            bfds_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .entry      (entries[g]),
                .keep       (keeps[g])
            );
        end
    endgenerate

    // While draining, count_reg holds the number of results still to go.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drain_reg <= 1'b0;
        end
        else if (drain_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_reg <= 1'b0;
            end
        end
        else if (obj.valid)
        begin
            count_reg <= count_after;
            if (obj.last && (count_after != '0))
            begin
                drain_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= drain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain_reg)
        begin
            sorted_id_reg   <= entries[0].id;
            distance_sq_reg <= entries[0].sq_dist;
            last_result_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign result_valid = result_valid_reg;
    assign sorted_id    = sorted_id_reg;
    assign distance_sq  = distance_sq_reg;
    assign last_result  = last_result_reg;

    // The fill level never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_OBJECTS))
        else $error("fill level beyond chain length");

    // Draining never runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (count_reg != '0))
        else $error("drain with empty chain");

    // A result that is not the final one is always followed by another.
    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> drain_reg)
        else $error("drain stopped before final result");

    // The final result ends the burst.
    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !result_valid)
        else $error("result after final result");

    // Accepting the last object holds off further objects.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_object) |=> busy)
        else $error("busy not raised after last object");

endmodule

// ===== sv/bfds_dist.sv =====
`timescale 1ns / 1ps

module bfds_dist
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [bfds_pkg::ID_W-1:0]       object_id,
    input  logic                            is_blend,
    input  logic                            last_object,
    input  logic signed [bfds_pkg::POS_W-1:0] pos_x,
    input  logic signed [bfds_pkg::POS_W-1:0] pos_y,
    input  logic signed [bfds_pkg::POS_W-1:0] pos_z,
    input  logic signed [bfds_pkg::POS_W-1:0] cam_x,
    input  logic signed [bfds_pkg::POS_W-1:0] cam_y,
    input  logic signed [bfds_pkg::POS_W-1:0] cam_z,
    output bfds_pkg::dist_t                 result,
    output logic                            last_pending
);

    // Stage one: magnitudes of the coordinate differences.
    logic                          s1_valid_reg;
    logic                          s1_blend_reg;
    logic                          s1_last_reg;
    logic [bfds_pkg::ID_W-1:0]     s1_id_reg;
    logic [bfds_pkg::MAG_W-1:0]    s1_mx_reg;
    logic [bfds_pkg::MAG_W-1:0]    s1_my_reg;
    logic [bfds_pkg::MAG_W-1:0]    s1_mz_reg;

    // Stage two: squares.
    logic                          s2_valid_reg;
    logic                          s2_blend_reg;
    logic                          s2_last_reg;
    logic [bfds_pkg::ID_W-1:0]     s2_id_reg;
    logic [bfds_pkg::SQ_W-1:0]     s2_qx_reg;
    logic [bfds_pkg::SQ_W-1:0]     s2_qy_reg;
    logic [bfds_pkg::SQ_W-1:0]     s2_qz_reg;

    // Stage three: sum of squares.
    logic                          s3_valid_reg;
    logic                          s3_blend_reg;
    logic                          s3_last_reg;
    logic [bfds_pkg::ID_W-1:0]     s3_id_reg;
    logic [bfds_pkg::DIST_W-1:0]   s3_dist_reg;

    logic [bfds_pkg::MAG_W-1:0]    mx_next;
    logic [bfds_pkg::MAG_W-1:0]    my_next;
    logic [bfds_pkg::MAG_W-1:0]    mz_next;

    function automatic logic [bfds_pkg::MAG_W-1:0] abs_diff(
        input logic signed [bfds_pkg::POS_W-1:0] p,
        input logic signed [bfds_pkg::POS_W-1:0] c
    );
        logic signed [bfds_pkg::POS_W:0] d;
        logic        [bfds_pkg::POS_W:0] n;
        d = {p[bfds_pkg::POS_W-1], p} - {c[bfds_pkg::POS_W-1], c};
        n = d[bfds_pkg::POS_W] ? (~d + 1'b1) : d;
        return n[bfds_pkg::MAG_W-1:0];
    endfunction

    always_comb
    begin
        mx_next = abs_diff(pos_x, cam_x);
        my_next = abs_diff(pos_y, cam_y);
        mz_next = abs_diff(pos_z, cam_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_blend_reg <= is_blend;
        s1_last_reg  <= last_object;
        s1_id_reg    <= object_id;
        s1_mx_reg    <= mx_next;
        s1_my_reg    <= my_next;
        s1_mz_reg    <= mz_next;

        s2_blend_reg <= s1_blend_reg;
        s2_last_reg  <= s1_last_reg;
        s2_id_reg    <= s1_id_reg;
        s2_qx_reg    <= s1_mx_reg * s1_mx_reg;
        s2_qy_reg    <= s1_my_reg * s1_my_reg;
        s2_qz_reg    <= s1_mz_reg * s1_mz_reg;

        s3_blend_reg <= s2_blend_reg;
        s3_last_reg  <= s2_last_reg;
        s3_id_reg    <= s2_id_reg;
        s3_dist_reg  <= {2'b00, s2_qx_reg} + {2'b00, s2_qy_reg} + {2'b00, s2_qz_reg};
    end

    always_comb
    begin
        result.valid   = s3_valid_reg;
        result.blend   = s3_blend_reg;
        result.last    = s3_last_reg;
        result.id      = s3_id_reg;
        result.sq_dist = s3_dist_reg;
        last_pending = (s1_valid_reg && s1_last_reg) || (s2_valid_reg && s2_last_reg)
                    || (s3_valid_reg && s3_last_reg);
    end

endmodule

// ===== sv/bfds_cell.sv =====
`timescale 1ns / 1ps

module bfds_cell
(
    input  logic             clk,
    input  bfds_pkg::ctrl_t  ctrl,
    input  logic             occupied,
    input  bfds_pkg::entry_t new_entry,
    input  bfds_pkg::entry_t prev_entry,
    input  logic             prev_keep,
    input  bfds_pkg::entry_t next_entry,
    output bfds_pkg::entry_t entry,
    output logic             keep
);

    bfds_pkg::entry_t entry_reg;
    bfds_pkg::entry_t entry_next;

    // An equal distance stays in front, so ties keep arrival order.
    assign keep = occupied && (entry_reg.sq_dist >= new_entry.sq_dist);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.ins && !keep)
        begin
            entry_next = prev_keep ? new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== bench/tb_back_to_front_depth_sort_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the back-to-front depth sort.
//
// A directed script runs first. It covers the reset camera and the extremes
// of position and camera. It covers a write to the unused register index,
// a non-blend closing object on an empty set, ties, and dropped objects.
// A random part follows. It is made of object sets of random size. Most
// sets are small, and one set overflows the chain so that the full-store
// case is reached. The camera is changed between sets, the extremes among
// the values.
//
// Every accepted transfer is passed to a predictor. The predictor keeps its
// own far-to-near list of kept objects and its own copy of the camera. The
// transfer that closes a set appends the expected results to a queue. A
// monitor pops that queue on every result strobe and compares each field.

module tb_back_to_front_depth_sort_top;

    localparam int ID_W      = bfds_pkg::ID_W;
    localparam int POS_W     = bfds_pkg::POS_W;
    localparam int DIST_W    = bfds_pkg::DIST_W;
    localparam int CFG_IDX_W = bfds_pkg::CFG_IDX_W;

    localparam int CHAIN_DEPTH = 64;
    localparam int RANDOM_ITEMS = 140;
    // No register sits behind this index, so a write to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic                    blend;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    last;
    } object_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] sq_dist;
        logic              last;
    } sorted_t;

    // How a script row is checked: by the predictor, against one typed-in
    // result, or against the absence of any result.
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_ONE, CHECK_NONE} check_t;
    typedef enum logic {ROW_OBJECT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        object_t               obj;
        check_t                check;
        logic [DIST_W-1:0]     exp_dist;
        logic [CFG_IDX_W-1:0]  widx;
        logic [POS_W-1:0]      wdata;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [ID_W-1:0]           object_id;
    logic                      is_blend;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic                      last_object;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [POS_W-1:0]          cfg_data;
    logic                      result_valid;
    logic [ID_W-1:0]           sorted_id;
    logic [DIST_W-1:0]         distance_sq;
    logic                      last_result;

    // The predictor's copy of the camera registers and of the kept objects,
    // with the farthest object at index 0.
    logic signed [POS_W-1:0]   cam_pos_x;
    logic signed [POS_W-1:0]   cam_pos_y;
    logic signed [POS_W-1:0]   cam_pos_z;
    bfds_pkg::entry_t          depth_order[$];
    // Results still owed by the block, oldest first.
    sorted_t                   owed_results[$];
    row_t                      script[$];
    int                        fail_count = 0;
    int                        burst_left = 0;

    back_to_front_depth_sort_top #(
        .MAX_OBJECTS (CHAIN_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .object_id    (object_id),
        .is_blend     (is_blend),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .last_object  (last_object),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .sorted_id    (sorted_id),
        .distance_sq  (distance_sq),
        .last_result  (last_result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The exact squared distance to the camera. Each difference needs 17
    // bits, so the sum is formed in 64 bits and always fits in 34.
    function automatic logic [DIST_W-1:0] distance_to_camera(input object_t o);
        longint dx;
        longint dy;
        longint dz;
        longint sum;
        dx = longint'($signed(o.x)) - longint'(cam_pos_x);
        dy = longint'($signed(o.y)) - longint'(cam_pos_y);
        dz = longint'($signed(o.z)) - longint'(cam_pos_z);
        sum = dx * dx + dy * dy + dz * dz;
        return sum[DIST_W-1:0];
    endfunction

    // Takes in one accepted object. A blend object goes behind every kept
    // object of equal or greater distance, so ties keep their arrival order.
    // A blend object that finds the store full is dropped. A closing object
    // hands back the whole list, far to near, and empties the store.
    function automatic void place_object(input object_t o, ref sorted_t produced[$]);
        bfds_pkg::entry_t fresh;
        int               slot;
        if (o.blend && depth_order.size() < CHAIN_DEPTH)
        begin
            fresh.sq_dist = distance_to_camera(o);
            fresh.id      = o.id;
            slot = 0;
            while (slot < depth_order.size() && depth_order[slot].sq_dist >= fresh.sq_dist)
                slot++;
            depth_order.insert(slot, fresh);
        end
        if (o.last)
        begin
            foreach (depth_order[k])
                produced.push_back('{id: depth_order[k].id, sq_dist: depth_order[k].sq_dist,
                                     last: (k == depth_order.size() - 1)});
            depth_order.delete();
        end
    endfunction

    // The sender works in bursts of back-to-back transfers. Between bursts
    // it leaves gaps of random length.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        // Now and then a burst follows with no gap at all.
        return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    function automatic logic [POS_W-1:0] edge_value();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic row_t object_row(input logic [ID_W-1:0] id, input logic blend,
                                        input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                        input logic [POS_W-1:0] z, input logic last,
                                        input check_t check = CHECK_MODEL,
                                        input logic [DIST_W-1:0] dist_val = '0);
        row_t r;
        r = '0;
        r.kind     = ROW_OBJECT;
        r.obj      = '{id: id, blend: blend, x: x, y: y, z: z, last: last};
        r.check    = check;
        r.exp_dist = dist_val;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [POS_W-1:0] data);
        row_t r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.widx  = idx;
        r.wdata = data;
        return r;
    endfunction

    // Offers one object and holds it until the block takes it. The caller
    // enters just after a rising edge. The task returns just after the edge
    // that completed the transfer, or after the gap that follows it. start
    // is left high when the next transfer follows at once.
    task automatic offer_object(input object_t o, input check_t check, input sorted_t want);
        sorted_t produced[$];
        int      gap;
        start       <= 1'b1;
        object_id   <= o.id;
        is_blend    <= o.blend;
        pos_x       <= o.x;
        pos_y       <= o.y;
        pos_z       <= o.z;
        last_object <= o.last;
        do
            @(posedge clk);
        while (busy);
        place_object(o, produced);
        if (check == CHECK_MODEL)
        begin
            foreach (produced[k])
                owed_results.push_back(produced[k]);
        end
        else if (check == CHECK_ONE)
            owed_results.push_back(want);
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets the block drain before the camera is touched. All owed results
    // must arrive first. A further wait then covers the distance pipeline
    // and the drain of the chain.
    task automatic settle_block();
        if (start)
            start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // A register write lasts one cycle, and cfg_we is low again before the task returns.
    // This way cfg_we is never lowered and raised within the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bfds_pkg::CFG_CAM_X: cam_pos_x = data;
            bfds_pkg::CFG_CAM_Y: cam_pos_y = data;
            bfds_pkg::CFG_CAM_Z: cam_pos_z = data;
            default:   ;
        endcase
        @(posedge clk);
    endtask

    // Result monitor. A result is shown for exactly one cycle and is taken
    // at the edge that ends that cycle. It is sampled here before that edge
    // updates anything.
    always @(posedge clk)
    begin : check_results
        sorted_t want;
        if (rst_n && result_valid)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with none expected: id %0d dist %0d last %0b",
                         $time, sorted_id, distance_sq, last_result);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (sorted_id !== want.id)
                begin
                    $display("%0t: sorted_id expected %0d actual %0d",
                             $time, want.id, sorted_id);
                    fail_count++;
                end
                if (distance_sq !== want.sq_dist)
                begin
                    $display("%0t: distance_sq expected %0d actual %0d",
                             $time, want.sq_dist, distance_sq);
                    fail_count++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result expected %0b actual %0b",
                             $time, want.last, last_result);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        object_t                 o;
        int                      random_sent;
        int                      phase;
        int                      set_size;
        logic signed [POS_W-1:0] prev_x;
        logic signed [POS_W-1:0] prev_y;
        logic signed [POS_W-1:0] prev_z;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        object_id   <= '0;
        is_blend    <= 1'b0;
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        last_object <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= bfds_pkg::CFG_CAM_X;
        cfg_data    <= '0;
        cam_pos_x   = '0;
        cam_pos_y   = '0;
        cam_pos_z   = '0;
        prev_x      = '0;
        prev_y      = '0;
        prev_z      = '0;

        // The directed script. Rows whose result can be read off by hand
        // carry it. All other rows go through the predictor.
        // After reset the camera sits at the origin. An object at the
        // origin is at distance zero.
        script.push_back(object_row(6'd5, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                    CHECK_ONE, 34'd0));
        // The most negative position against the reset camera.
        script.push_back(object_row(6'd63, 1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b1,
                                    CHECK_ONE, 34'd3221225472));
        // A non-blend object closes an empty set, so there are no results.
        script.push_back(object_row(6'd0, 1'b0, 16'h7FFF, 16'hFFFF, 16'h0100, 1'b1,
                                    CHECK_NONE));
        // The camera at the positive corner and the object at the negative
        // corner give the largest distance there is.
        script.push_back(write_row(bfds_pkg::CFG_CAM_X, 16'h7FFF));
        script.push_back(write_row(bfds_pkg::CFG_CAM_Y, 16'h7FFF));
        script.push_back(write_row(bfds_pkg::CFG_CAM_Z, 16'h7FFF));
        script.push_back(object_row(6'd42, 1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b1,
                                    CHECK_ONE, 34'd12884508675));
        // A write to the unused index must leave the camera where it is.
        script.push_back(write_row(CFG_UNUSED, 16'h8000));
        script.push_back(object_row(6'd1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
                                    CHECK_ONE, 34'd0));
        // Ties, dropped objects and a non-blend object that closes a
        // populated set.
        script.push_back(write_row(bfds_pkg::CFG_CAM_X, 16'h8000));
        script.push_back(write_row(bfds_pkg::CFG_CAM_Y, 16'h0000));
        script.push_back(write_row(bfds_pkg::CFG_CAM_Z, 16'h1234));
        script.push_back(object_row(6'd10, 1'b1, 16'h0100, 16'h0200, 16'h0300, 1'b0));
        script.push_back(object_row(6'd11, 1'b1, 16'h0100, 16'h0200, 16'h0300, 1'b0));
        script.push_back(object_row(6'd12, 1'b0, 16'hFFFB, 16'h0007, 16'h0009, 1'b0));
        script.push_back(object_row(6'd13, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 1'b0));
        script.push_back(object_row(6'd14, 1'b1, 16'h0100, 16'h0200, 16'h0300, 1'b0));
        script.push_back(object_row(6'd15, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        // Alternating bit patterns, and a blend object that closes its set.
        script.push_back(write_row(bfds_pkg::CFG_CAM_Y, 16'h5A5A));
        script.push_back(write_row(bfds_pkg::CFG_CAM_Z, 16'hA5A5));
        script.push_back(object_row(6'd20, 1'b1, 16'h5555, 16'hAAAA, 16'h0F0F, 1'b0));
        script.push_back(object_row(6'd21, 1'b1, 16'hAAAA, 16'h5555, 16'hF0F0, 1'b0));
        script.push_back(object_row(6'd22, 1'b1, 16'h00FF, 16'hFF00, 16'h3C3C, 1'b1));

        // Reset is held low from time zero and released at a rising edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(script[i].widx, script[i].wdata);
            end
            else
                offer_object(script[i].obj, script[i].check,
                             '{id: script[i].obj.id, sq_dist: script[i].exp_dist,
                               last: 1'b1});
        end

        // Random sets. Each set closes with a last object. The third set is
        // longer than the chain, so the later blend objects find it full.
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            // The camera may only move while the block is idle, so a new
            // camera means a full drain first. Some sets instead follow
            // their predecessor at once, with start held high while the
            // block is still emitting.
            if ($urandom_range(0, 2) != 0)
            begin
                settle_block();
                for (int r = bfds_pkg::CFG_CAM_X; r <= bfds_pkg::CFG_CAM_Z; r++)
                    if ($urandom_range(0, 9) < 6)
                        write_reg(r[CFG_IDX_W-1:0],
                                  ($urandom_range(0, 2) == 0) ? edge_value()
                                                             : POS_W'($urandom));
                if ($urandom_range(0, 4) == 0)
                    write_reg(CFG_UNUSED, POS_W'($urandom));
            end

            set_size = (phase == 2) ? CHAIN_DEPTH + $urandom_range(2, 6)
                                    : $urandom_range(1, 10);
            for (int n = 0; n < set_size; n++)
            begin
                o.id    = ID_W'($urandom);
                o.blend = (phase == 2) || ($urandom_range(0, 3) != 0);
                o.last  = (n == set_size - 1);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        o.x = POS_W'($urandom);
                        o.y = POS_W'($urandom);
                        o.z = POS_W'($urandom);
                    end
                    1:
                    begin
                        // Close to the camera, so that distances are small
                        // and often equal.
                        o.x = cam_pos_x + POS_W'($urandom_range(0, 15)) - 16'd8;
                        o.y = cam_pos_y + POS_W'($urandom_range(0, 15)) - 16'd8;
                        o.z = cam_pos_z + POS_W'($urandom_range(0, 15)) - 16'd8;
                    end
                    2:
                    begin
                        // The position of the previous object forces a tie.
                        o.x = prev_x;
                        o.y = prev_y;
                        o.z = prev_z;
                    end
                    default:
                    begin
                        o.x = edge_value();
                        o.y = edge_value();
                        o.z = edge_value();
                    end
                endcase
                prev_x = o.x;
                prev_y = o.y;
                prev_z = o.z;
                offer_object(o, CHECK_MODEL, '0);
                random_sent++;
            end
            phase++;
        end

        settle_block();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && owed_results.size() == 0)
            $display("tb_back_to_front_depth_sort_top passed");
        else
            $display("tb_back_to_front_depth_sort_top failed");
        $finish;
    end

    // Guard against a hung handshake. A correct run ends well inside this
    // limit.
    initial
    begin
        #400000;
        $display("tb_back_to_front_depth_sort_top failed");
        $finish;
    end

endmodule
